>>> src/radc_pkg.sv
// Shared types and constants for the ramp converter sequencer.
`default_nettype none

package radc_pkg;

    // Field and register widths
    localparam int DT_W    = 20;   // discharge_ticks
    localparam int CAP_W   = 16;   // count_cap
    localparam int RPS_W   = 4;    // reads_per_sum
    localparam int PHASE_W = 20;   // phase counter
    localparam int SUM_W   = 20;   // running sum
    localparam int CFG_W   = 20;   // config write data
    localparam int REG_IDX_W = 2;

    // Register reset values
    localparam logic [DT_W-1:0]  DT_RESET  = 20'd10000;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd50000;
    localparam logic [RPS_W-1:0] RPS_RESET = 4'd10;

    // Divide by ten: q = (v * RECIP_MUL) >> RECIP_SHIFT, exact for any 20-bit v
    localparam logic [SUM_W-1:0] RECIP_MUL = 20'd838861;
    localparam int RECIP_SHIFT = 23;

    // Characters
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LF   = 8'd10;
    localparam logic [7:0] ASCII_CR   = 8'd13;

    // Tick-to-formatter queue
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DISCHARGE_TICKS = 2'd0,
        REG_COUNT_CAP       = 2'd1,
        REG_READS_PER_SUM   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } back_state_t;

    // One processed tick, handed from the sequencer to the formatter
    typedef struct packed {
        logic             drive;
        logic             emit;
        logic [SUM_W-1:0] sum;
    } job_t;

endpackage

`default_nettype wire

>>> src/radc_front.sv
// Tick sequencer: config registers, discharge/ramp phases and sum accumulation.
`default_nettype none

module radc_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_write,
    input  wire logic [radc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [radc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            tick_accept,
    input  wire logic                            comparator_high,
    output radc_pkg::job_t                       job
);
    import radc_pkg::*;

    logic [DT_W-1:0]    dt_reg, dt_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [RPS_W-1:0]   rps_reg, rps_next;
    logic               dis_reg, dis_next;
    logic [PHASE_W-1:0] pc_reg, pc_next;
    logic [RPS_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic [PHASE_W-1:0] pc_inc;
    logic [PHASE_W-1:0] cap_ext;
    logic [SUM_W-1:0]   reading;
    logic [SUM_W-1:0]   sum_add;
    logic [RPS_W-1:0]   idx_inc;
    logic               have_reading;
    logic               emit;

    assign pc_inc  = pc_reg + PHASE_W'(1);
    assign cap_ext = PHASE_W'(cap_reg);
    assign sum_add = sum_reg + reading;
    assign idx_inc = idx_reg + RPS_W'(1);

    always_comb begin
        dt_next  = dt_reg;
        cap_next = cap_reg;
        rps_next = rps_reg;
        if (cfg_write) begin
            unique case (reg_index_t'(cfg_index))
                REG_DISCHARGE_TICKS: dt_next  = cfg_data[DT_W-1:0];
                REG_COUNT_CAP:       cap_next = cfg_data[CAP_W-1:0];
                REG_READS_PER_SUM:   rps_next = cfg_data[RPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        dis_next     = dis_reg;
        pc_next      = pc_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        have_reading = 1'b0;
        reading      = '0;
        emit         = 1'b0;
        if (tick_accept) begin
            if (dis_reg) begin
                // discharge lasts at least one tick even at zero
                if (pc_inc >= dt_reg) begin
                    dis_next = 1'b0;
                    pc_next  = '0;
                end else begin
                    pc_next = pc_inc;
                end
            end else if (comparator_high) begin
                have_reading = 1'b1;
                reading      = SUM_W'((pc_reg < cap_ext) ? pc_reg : cap_ext);
            end else if (pc_inc >= cap_ext) begin
                have_reading = 1'b1;
                reading      = SUM_W'(cap_ext);
            end else begin
                pc_next = pc_inc;
            end

            if (have_reading) begin
                dis_next = 1'b1;
                pc_next  = '0;
                // zero reads-per-sum falls out of the compare
                if (idx_inc >= rps_reg) begin
                    emit     = 1'b1;
                    sum_next = '0;
                    idx_next = '0;
                end else begin
                    sum_next = sum_add;
                    idx_next = idx_inc;
                end
            end
        end
    end

    assign job.drive = dis_reg;
    assign job.emit  = emit;
    assign job.sum   = sum_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg  <= DT_RESET;
            cap_reg <= CAP_RESET;
            rps_reg <= RPS_RESET;
            dis_reg <= 1'b1;
            pc_reg  <= '0;
            idx_reg <= '0;
            sum_reg <= '0;
        end else begin
            dt_reg  <= dt_next;
            cap_reg <= cap_next;
            rps_reg <= rps_next;
            dis_reg <= dis_next;
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> src/radc_queue.sv
// Short job queue between the tick sequencer and the character formatter.
`default_nettype none

module radc_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  radc_pkg::job_t push_data,
    output logic           full,
    input  wire logic      pop,
    output radc_pkg::job_t pop_data,
    output logic           not_empty
);
    import radc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> src/radc_back.sv
// Character formatter: binary sum to decimal digits, LF, CR, with an output register.
`default_nettype none

module radc_back #(
    parameter int DIGIT_COUNT = 10
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      job_valid,
    input  radc_pkg::job_t job,
    output logic           job_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic           out_drive,
    output logic           out_char_valid,
    output logic [7:0]     out_char_code,
    output logic           out_last
);
    import radc_pkg::*;

    localparam int CNT_W = $clog2(DIGIT_COUNT + 2);

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] v_reg, v_next;
    logic             drive_reg, drive_next;
    logic [3:0]       dig_reg [DIGIT_COUNT];
    logic [3:0]       dig_next [DIGIT_COUNT];

    logic             valid_reg, valid_next;
    logic             odrive_reg, odrive_next;
    logic             ocv_reg, ocv_next;
    logic [7:0]       ocode_reg, ocode_next;
    logic             olast_reg, olast_next;

    logic                 out_free;
    logic [2*SUM_W-1:0]   prod;
    logic [SUM_W-1:0]     quot;
    logic [SUM_W-1:0]     quot10;
    logic [3:0]           digit;

    // one decimal digit per cycle, least significant first
    assign prod   = v_reg * RECIP_MUL;
    assign quot   = SUM_W'(prod[2*SUM_W-1:RECIP_SHIFT]);
    assign quot10 = (quot << 3) + (quot << 1);
    assign digit  = 4'(v_reg - quot10);

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        v_next      = v_reg;
        drive_next  = drive_reg;
        dig_next    = dig_reg;
        valid_next  = valid_reg && !m_tready;
        odrive_next = odrive_reg;
        ocv_next    = ocv_reg;
        ocode_next  = ocode_reg;
        olast_next  = olast_reg;
        job_pop     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid && out_free) begin
                    job_pop = 1'b1;
                    if (job.emit) begin
                        v_next     = job.sum;
                        drive_next = job.drive;
                        cnt_next   = '0;
                        state_next = ST_CONV;
                    end else begin
                        valid_next  = 1'b1;
                        odrive_next = job.drive;
                        ocv_next    = 1'b0;
                        ocode_next  = '0;
                        olast_next  = 1'b1;
                    end
                end
            end
            ST_CONV: begin
                v_next      = quot;
                dig_next[0] = digit;
                for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                    dig_next[i+1] = dig_reg[i];
                end
                if (cnt_reg == CNT_W'(DIGIT_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    odrive_next = drive_reg;
                    ocv_next    = 1'b1;
                    olast_next  = 1'b0;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    if (cnt_reg < CNT_W'(DIGIT_COUNT)) begin
                        // most significant digit sits at the head
                        ocode_next = ASCII_ZERO | {4'b0000, dig_reg[0]};
                        for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                            dig_next[i] = dig_reg[i+1];
                        end
                    end else if (cnt_reg == CNT_W'(DIGIT_COUNT)) begin
                        ocode_next = ASCII_LF;
                    end else begin
                        ocode_next = ASCII_CR;
                        olast_next = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        drive_reg  <= drive_next;
        dig_reg    <= dig_next;
        odrive_reg <= odrive_next;
        ocv_reg    <= ocv_next;
        ocode_reg  <= ocode_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid       = valid_reg;
    assign out_drive      = odrive_reg;
    assign out_char_valid = ocv_reg;
    assign out_char_code  = ocode_reg;
    assign out_last       = olast_reg;

`ifndef SYNTH
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !job_pop)
        else $error("job taken while a burst is in progress");
    a_idle_item: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !ocv_reg |-> olast_reg && ocode_reg == 8'h00)
        else $error("malformed no-character item");
    a_last_is_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && ocv_reg && olast_reg |-> ocode_reg == ASCII_CR)
        else $error("burst closed by a character other than CR");
    a_conv_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV && !$past(valid_reg) |-> !valid_reg)
        else $error("output raised during conversion");
`endif

endmodule

`default_nettype wire

>>> src/ramp_adc_sum_decimal_out.sv
// Top level of the single-slope ramp converter sequencer with decimal sum output.
//
// Usage:
//   s_* : one request per timebase tick; s_tdata[0] is the comparator level.
//         Each tick either advances the discharge phase or counts the ramp.
//   m_* : one or more requests per tick. An ordinary tick gives one request
//         with m_tuser (char valid) low and m_tlast high. The tick that
//         completes a sum gives DIGIT_COUNT decimal digits, LF and CR, with
//         m_tlast on the CR. m_tdata[0] is the discharge drive for that tick.
//   cfg_*: register writes (0 discharge ticks, 1 count cap, 2 reads per sum),
//          always ready; write only while no ticks are in flight.
// Throughput: one tick per cycle while the output keeps up. A sum burst
//   occupies the formatter for DIGIT_COUNT digit conversions (one
//   divide-by-ten per cycle) plus DIGIT_COUNT + 2 characters.
// An ordinary tick's request passes through the queue and the output register.
// Ticks are processed at acceptance into a 4-entry queue; when the output
//   stalls the queue fills and s_tready drops, so no tick is lost.
// Reset: registers return to 10000 / 50000 / 10, the sequencer starts in
//   discharge with zero count, index and sum; queue and output empty.
`default_nettype none

module ramp_adc_sum_decimal_out #(
    parameter int DIGIT_COUNT = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [radc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [radc_pkg::CFG_W-1:0]      cfg_data,
    // tick input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [0] comparator_high, [7:1] zero
    // character output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // [0] discharge_on, [8:1] char_code, [15:9] zero
    output logic                                 m_tuser,   // [0] char_valid
    output logic                                 m_tlast    // last_char
);
    import radc_pkg::*;

    job_t       front_job;
    job_t       queue_job;
    logic       tick_accept;
    logic       queue_full;
    logic       queue_valid;
    logic       queue_pop;
    logic       out_drive;
    logic       out_char_valid;
    logic [7:0] out_char_code;
    logic       out_last;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !queue_full;
    assign tick_accept = s_tvalid && s_tready;

    radc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .tick_accept     (tick_accept),
        .comparator_high (s_tdata[0]),
        .job             (front_job)
    );

    radc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tick_accept),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_job),
        .not_empty (queue_valid)
    );

    radc_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (queue_valid),
        .job            (queue_job),
        .job_pop        (queue_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_drive      (out_drive),
        .out_char_valid (out_char_valid),
        .out_char_code  (out_char_code),
        .out_last       (out_last)
    );

    assign m_tdata = {7'b0000000, out_char_code, out_drive};
    assign m_tuser = out_char_valid;
    assign m_tlast = out_last;

endmodule

`default_nettype wire
